>>> rtl/alternating_bit_sender_top_defines.svh
// Assertion macros shared by the alternating-bit sender RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ALTERNATING_BIT_SENDER_TOP_DEFINES_SVH
`define ALTERNATING_BIT_SENDER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define ABS_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define ABS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define ABS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/abs_pkg.sv
// Shared types, codes and the packet checksum for the alternating-bit sender.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package abs_pkg;

    // Payload geometry.
    localparam int PAYLOAD_BYTES = 20;
    localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
    localparam int GROUP_BYTES   = 4;
    localparam int GROUPS        = PAYLOAD_BYTES / GROUP_BYTES;
    localparam int CSUM_W        = 13;

    // Event kinds carried with each request.
    localparam logic [1:0] FUNC_MSG   = 2'd0;
    localparam logic [1:0] FUNC_ACK   = 2'd1;
    localparam logic [1:0] FUNC_TIMER = 2'd2;

    // Timer actions reported with each result.
    localparam logic [1:0] TIMER_NONE  = 2'd0;
    localparam logic [1:0] TIMER_START = 2'd1;
    localparam logic [1:0] TIMER_STOP  = 2'd2;

    // Twenty payload bytes, byte 0 in the lowest bits.
    typedef struct packed {
        logic [31:0] high;
        logic [63:0] mid;
        logic [63:0] low;
    } payload_t;

    // Queue control from the protocol logic.
    typedef struct packed {
        logic push;
        logic pop;
    } q_cmd_t;

    // Queue status towards the protocol logic.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // One result item.
    typedef struct packed {
        logic                     drop_flag;
        logic [1:0]               timer_cmd;
        payload_t                 payload;
        logic signed [CSUM_W-1:0] checksum;
        logic                     seq;
        logic                     send_valid;
    } res_t;

    // Sum of the payload bytes as signed values plus twice the sequence bit.
    // The bytes are added in groups of four, then the group sums together.
    function automatic logic signed [CSUM_W-1:0] abs_csum(input payload_t p, input logic seq);
        logic [PAYLOAD_W-1:0]     flat;
        logic [7:0]               b;
        logic signed [CSUM_W-1:0] grp;
        logic signed [CSUM_W-1:0] total;
        flat  = p;
        total = {{(CSUM_W-2){1'b0}}, seq, 1'b0};
        for (int g = 0; g < GROUPS; g++)
        begin
            grp = '0;
            for (int k = 0; k < GROUP_BYTES; k++)
            begin
                b   = flat[8*(GROUP_BYTES*g+k) +: 8];
                grp = grp + {{(CSUM_W-8){b[7]}}, b};
            end
            total = total + grp;
        end
        return total;
    endfunction

endpackage

`default_nettype wire

>>> rtl/abs_queue.sv
// Message queue of the alternating-bit sender: payload memory, pointers, count.
// The head entry is read ahead into a register, with a bypass for a write to it.
// Depends on abs_pkg.
`default_nettype none
`include "alternating_bit_sender_top_defines.svh"

module abs_queue
    import abs_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire q_cmd_t   cmd,
    input  wire payload_t wr_data,
    output q_stat_t       stat,
    output payload_t      head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    payload_t        mem [DEPTH];
    payload_t        head_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            bypass;

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (cmd.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (cmd.push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        case ({cmd.push, cmd.pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // A write to the entry that becomes the head is forwarded past the memory.
    assign bypass = cmd.push && (wr_ptr_reg == rd_ptr_next);

    // Memory write and registered read-ahead of the next head entry.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        head_reg <= bypass ? wr_data : mem[rd_ptr_next];
    end

    assign head       = head_reg;
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);

    `ABS_ASSERT(a_count_range, count_reg <= CW'(DEPTH), "queue count beyond depth")
    `ABS_ASSERT_IMPL(a_no_overflow, cmd.push, !stat.full, "push into a full queue")
    `ABS_ASSERT_IMPL(a_no_underflow, cmd.pop, !stat.empty || cmd.push, "pop from an empty queue")

endmodule

`default_nettype wire

>>> rtl/abs_ctrl.sv
// Protocol logic of the alternating-bit sender: sequence bit, outstanding
// packet, ack checking and the result of each event. Depends on abs_pkg.
`default_nettype none
`include "alternating_bit_sender_top_defines.svh"

module abs_ctrl
    import abs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic [1:0]  func,
    input  wire payload_t    payload,
    input  wire logic [31:0] ack_seqnum,
    input  wire logic [31:0] ack_number,
    input  wire logic [31:0] ack_checksum,
    input  wire q_stat_t     q_stat,
    input  wire payload_t    q_head,
    output q_cmd_t           q_cmd,
    output res_t             res
);

    logic                     seq_reg;
    logic                     seq_next;
    logic                     awaiting_reg;
    logic                     awaiting_next;
    payload_t                 held_reg;
    payload_t                 held_next;
    logic signed [CSUM_W-1:0] held_sum_reg;
    logic signed [CSUM_W-1:0] held_sum_next;
    logic                     ack_ok;
    logic                     new_send;
    payload_t                 new_pay;
    logic signed [CSUM_W-1:0] new_sum;

    // An ack counts when its checksum is right, it names the outstanding bit
    // and a packet is actually outstanding.
    assign ack_ok = (ack_checksum == (ack_seqnum + ack_number))
                    && (ack_number == {31'd0, seq_reg}) && awaiting_reg;

    // Event decode and result.
    always_comb
    begin
        seq_next      = seq_reg;
        awaiting_next = awaiting_reg;
        q_cmd         = '0;
        res           = '0;
        new_send      = 1'b0;
        new_pay       = payload;
        if (fire)
        begin
            unique case (func)
                FUNC_MSG:
                begin
                    if (q_stat.full)
                    begin
                        res.drop_flag = 1'b1;
                    end
                    else
                    begin
                        q_cmd.push = 1'b1;
                        // Nothing outstanding means the queue is empty, so the
                        // new message is the head and leaves at once.
                        if (!awaiting_reg)
                        begin
                            q_cmd.pop     = 1'b1;
                            new_send      = 1'b1;
                            awaiting_next = 1'b1;
                        end
                    end
                end
                FUNC_ACK:
                begin
                    if (ack_ok)
                    begin
                        seq_next      = ~seq_reg;
                        awaiting_next = 1'b0;
                        if (!q_stat.empty)
                        begin
                            q_cmd.pop     = 1'b1;
                            new_send      = 1'b1;
                            new_pay       = q_head;
                            awaiting_next = 1'b1;
                        end
                        else
                        begin
                            res.timer_cmd = TIMER_STOP;
                        end
                    end
                end
                FUNC_TIMER:
                begin
                    if (awaiting_reg)
                    begin
                        res.send_valid = 1'b1;
                        res.seq        = seq_reg;
                        res.checksum   = held_sum_reg;
                        res.payload    = held_reg;
                        res.timer_cmd  = TIMER_START;
                    end
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
        new_sum = abs_csum(new_pay, seq_next);
        if (new_send)
        begin
            res.send_valid = 1'b1;
            res.seq        = seq_next;
            res.checksum   = new_sum;
            res.payload    = new_pay;
            res.timer_cmd  = TIMER_START;
        end
    end

    // The outstanding packet is kept for resends.
    assign held_next     = new_send ? new_pay : held_reg;
    assign held_sum_next = new_send ? new_sum : held_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg      <= 1'b0;
            awaiting_reg <= 1'b0;
        end
        else
        begin
            seq_reg      <= seq_next;
            awaiting_reg <= awaiting_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg     <= held_next;
        held_sum_reg <= held_sum_next;
    end

    `ABS_ASSERT_IMPL(a_idle_empty, !awaiting_reg, q_stat.empty,
        "messages wait with none outstanding")
    `ABS_ASSERT_NEXT(a_send_awaits, res.send_valid, awaiting_reg,
        "packet sent but none outstanding")
    `ABS_ASSERT_IMPL(a_drop_full, res.drop_flag, q_stat.full,
        "message dropped with room in queue")
    `ABS_ASSERT_NEXT(a_ack_toggle, fire && (func == FUNC_ACK) && ack_ok,
        seq_reg != $past(seq_reg), "accepted ack did not toggle the bit")

endmodule

`default_nettype wire

>>> rtl/alternating_bit_sender_top.sv
// Alternating-bit sender: request and result registers around the protocol
// logic and the message queue. Depends on abs_pkg, abs_ctrl and abs_queue.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the event kind
//   (message, ack, timer expiry), tdata the payload and the ack fields.
//   Every request gives exactly one result on the m_axis channel: tuser
//   flags a packet sent and a dropped message, tdata carries the packet's
//   sequence bit, checksum, payload and the timer command.
//   A request is taken into an input register; once the result register is
//   free, it is evaluated against the protocol state and queue head and the
//   result register is loaded. One request is taken every cycle while the
//   receiver holds tready high, set by the single pass through the checksum
//   adder tree and the queue update between the two registers.
//   When the receiver holds tready low, the result register holds its item,
//   the input register keeps the next request, and s_axis tready falls once
//   both are full. Reset empties the queue, clears the sequence bit and the
//   outstanding flag and loads the retransmission timeout with 11 ticks.
//   cfg_we writes timeout_ticks from cfg_wdata; the user must write it only
//   while idle, and the block itself does not enforce this.
`default_nettype none
`include "alternating_bit_sender_top_defines.svh"

module alternating_bit_sender_top
    import abs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Configuration write of timeout_ticks.
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,
    // Request channel.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // payload_low[63:0], payload_mid[127:64], payload_high[159:128],
    // ack_seqnum[191:160], ack_number[223:192], ack_checksum[255:224]
    input  wire logic [255:0] s_axis_tdata,
    // func[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    // Result channel.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // send_seq[0], send_checksum[13:1], send_payload_low[77:14],
    // send_payload_mid[141:78], send_payload_high[173:142], timer_cmd[175:174]
    output logic [175:0]      m_axis_tdata,
    // send_valid[0], drop_flag[1]
    output logic [1:0]        m_axis_tuser
);

    logic           in_valid_reg;
    logic [255:0]   in_data_reg;
    logic [1:0]     in_func_reg;
    logic           out_valid_reg;
    res_t           out_res_reg;
    logic [15:0]    timeout_ticks_reg;
    logic           advance;
    logic           fire;
    logic           s_accept;
    q_cmd_t         q_cmd;
    q_stat_t        q_stat;
    payload_t       q_head;
    payload_t       in_payload;
    res_t           res;

    // Handshake: the result register frees when empty or being taken.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Configuration register; it is only stored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= 16'd11;
        end
        else if (cfg_we)
        begin
            timeout_ticks_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_data_reg <= s_axis_tdata;
            in_func_reg <= s_axis_tuser;
        end
    end

    assign in_payload = payload_t'(in_data_reg[PAYLOAD_W-1:0]);

    abs_queue #(
        .DEPTH   (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (q_cmd),
        .wr_data (in_payload),
        .stat    (q_stat),
        .head    (q_head)
    );

    abs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .func         (in_func_reg),
        .payload      (in_payload),
        .ack_seqnum   (in_data_reg[191:160]),
        .ack_number   (in_data_reg[223:192]),
        .ack_checksum (in_data_reg[255:224]),
        .q_stat       (q_stat),
        .q_head       (q_head),
        .q_cmd        (q_cmd),
        .res          (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    // Result packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.timer_cmd,
                            out_res_reg.payload.high,
                            out_res_reg.payload.mid,
                            out_res_reg.payload.low,
                            out_res_reg.checksum,
                            out_res_reg.seq};
    assign m_axis_tuser  = {out_res_reg.drop_flag, out_res_reg.send_valid};

    `ABS_ASSERT_NEXT(a_cfg_write, cfg_we, timeout_ticks_reg == $past(cfg_wdata),
        "timeout register not written")
    `ABS_ASSERT_IMPL(a_no_overwrite, fire, !m_axis_tvalid || m_axis_tready,
        "result register overwritten while held")
    `ABS_ASSERT_NEXT(a_request_kept, in_valid_reg && !fire, in_valid_reg,
        "waiting request lost")

endmodule

`default_nettype wire
